// ----- hdl/assert_macros.svh -----
// assertion macros for rtl files that check themselves; only the responder top level includes them
// depends on nothing; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bmsbi_pkg.sv -----
// types, constants and the command byte, value mask and frame byte functions for the basic-info responder
// depends on nothing
`default_nettype none

package bmsbi_pkg;

  localparam int NumValues = 22;
  localparam int CmdLen    = 7;
  localparam int FrameLen  = 40;

  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [7:0] BYTE_START  = 8'hDD;
  localparam logic [7:0] BYTE_READ   = 8'h03;
  localparam logic [7:0] BYTE_STATUS = 8'h00;
  localparam logic [7:0] BYTE_LEN    = 8'd33;
  localparam logic [7:0] BYTE_STOP   = 8'h77;
  localparam logic [7:0] MOS_CHG     = 8'h01;
  localparam logic [7:0] MOS_DSG     = 8'h02;
  localparam logic [15:0] TEMP_OFFS  = 16'd2731;
  localparam logic [15:0] YEAR_BASE  = 16'd2000;

  localparam logic [9:0] ELAPSED_MAX = 10'd1023;
  localparam logic [7:0] PENDING_MAX = 8'd255;
  localparam logic [9:0] DELAY_RST   = 10'd15;

  typedef logic [NumValues-1:0][31:0] value_tbl_t;

  typedef struct packed {
    logic take;
    logic busy;
  } bk_stat_t;

  function automatic logic [7:0] cmd_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'hDD;
      3'd1:    b = 8'hA5;
      3'd2:    b = 8'h03;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'hFF;
      3'd5:    b = 8'hFD;
      3'd6:    b = 8'h77;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] value_mask(input logic [4:0] idx);
    logic [31:0] m;
    case (idx)
      5'd0, 5'd7, 5'd8, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16: m = 32'h0000_00FF;
      5'd9:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] frame_byte(input value_tbl_t tbl, input logic [5:0] idx,
                                            input logic [15:0] chk);
    logic [15:0] w;
    logic [15:0] yr;
    logic        hi;
    logic [7:0]  b;
    yr = tbl[6][15:0] - YEAR_BASE;
    w  = 16'd0;
    case (idx)
      6'd4, 6'd5:   w = tbl[1][15:0];
      6'd6, 6'd7:   w = tbl[2][15:0];
      6'd8, 6'd9:   w = tbl[3][15:0];
      6'd10, 6'd11: w = tbl[4][15:0];
      6'd12, 6'd13: w = tbl[5][15:0];
      6'd14, 6'd15: w = (yr << 9) | ({8'd0, tbl[7][7:0]} << 5) | {8'd0, tbl[8][7:0]};
      6'd16, 6'd17: w = tbl[9][31:16];
      6'd18, 6'd19: w = tbl[9][15:0];
      6'd20, 6'd21: w = tbl[10][15:0];
      6'd27, 6'd28: w = tbl[17][15:0] + TEMP_OFFS;
      6'd29, 6'd30: w = tbl[18][15:0] + TEMP_OFFS;
      6'd31, 6'd32: w = tbl[19][15:0] + TEMP_OFFS;
      6'd33, 6'd34: w = tbl[20][15:0] + TEMP_OFFS;
      6'd35, 6'd36: w = tbl[21][15:0] + TEMP_OFFS;
      6'd37, 6'd38: w = chk;
      default:      w = 16'd0;
    endcase
    // pairs start on even bytes up to 21, on odd bytes from 27 on
    hi = (idx < 6'd27) ? ~idx[0] : idx[0];
    b  = hi ? w[15:8] : w[7:0];
    case (idx)
      6'd0:    b = BYTE_START;
      6'd1:    b = BYTE_READ;
      6'd2:    b = BYTE_STATUS;
      6'd3:    b = BYTE_LEN;
      6'd22:   b = tbl[11][7:0];
      6'd23:   b = tbl[12][7:0];
      6'd24:   b = ((tbl[13] != 32'd0) ? MOS_CHG : 8'h00) |
                   ((tbl[14] != 32'd0) ? MOS_DSG : 8'h00);
      6'd25:   b = tbl[15][7:0];
      6'd26:   b = tbl[16][7:0];
      6'd39:   b = BYTE_STOP;
      default: b = b;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bmsbi_outq.sv -----
// two-entry result queue between the frame serializer and the result ports
// depends on nothing
`default_nettype none

module bmsbi_outq (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_byte,
  input  wire logic       wr_end,
  output logic            q_full,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      tx_byte,
  output logic            frame_end
);

  logic [1:0][8:0] ent_r;
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign empty     = (cnt_r == 2'd0);
  assign q_full    = (cnt_r == 2'd2);
  assign do_wr     = wr_en & ~q_full;
  assign do_rd     = pop & ~empty;
  assign tx_byte   = ent_r[rp_r][8:1];
  assign frame_end = ent_r[rp_r][0];

  always_comb begin
    wp_nxt  = wp_r ^ do_wr;
    rp_nxt  = rp_r ^ do_rd;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= {wr_byte, wr_end};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bmsbi_front.sv -----
// front part: command matcher, pending/elapsed counters, value table, job slot
// depends on bmsbi_pkg
`default_nettype none

module bmsbi_front import bmsbi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [4:0]  in_value_index,
  input  wire logic [31:0] in_value_data,
  input  wire logic [9:0]  delay,
  input  wire bk_stat_t    bk_stat,
  output logic             job_valid,
  output value_tbl_t       tbl
);

  value_tbl_t  tbl_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  pend_r, pend_nxt, pend_a;
  logic [9:0]  elap_r, elap_nxt, elap_a;
  logic        job_r, job_nxt;
  logic        acc, wr_en, fire;
  logic [7:0]  val0_n;

  assign acc       = in_push & ~in_full;
  assign in_full   = job_r | bk_stat.busy;
  assign job_valid = job_r;
  assign tbl       = tbl_r;
  assign wr_en     = acc && (in_opcode == OP_WRITE) && (in_value_index < 5'(NumValues));

  always_comb begin
    pos_nxt = pos_r;
    pend_a  = pend_r;
    elap_a  = elap_r;
    if (acc) begin
      case (in_opcode)
        OP_RX: begin
          if (in_rx_byte == cmd_byte(pos_r)) begin
            if (pos_r == 3'(CmdLen - 1)) begin
              pos_nxt = 3'd0;
              if (pend_r == 8'd0) elap_a = 10'd0;
              if (pend_r != PENDING_MAX) pend_a = pend_r + 8'd1;
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end else begin
            pos_nxt = 3'd0;
          end
        end
        OP_TICK: begin
          if (elap_r != ELAPSED_MAX) elap_a = elap_r + 10'd1;
        end
        default: begin
        end
      endcase
    end
    // valid entry as it stands after this item's write
    val0_n   = (wr_en && in_value_index == 5'd0) ? in_value_data[7:0] : tbl_r[0][7:0];
    fire     = acc && (pend_a != 8'd0) && (elap_a >= delay);
    pend_nxt = fire ? pend_a - 8'd1 : pend_a;
    elap_nxt = fire ? 10'd0 : elap_a;
    job_nxt  = (job_r & ~bk_stat.take) | (fire & (val0_n != 8'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r  <= '0;
      pos_r  <= 3'd0;
      pend_r <= 8'd0;
      elap_r <= 10'd0;
      job_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
      elap_r <= elap_nxt;
      job_r  <= job_nxt;
      if (wr_en) begin
        tbl_r[in_value_index] <= in_value_data & value_mask(in_value_index);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bmsbi_back.sv -----
// back part: serializes one 40-byte response frame into the result queue
// depends on bmsbi_pkg and bmsbi_outq
`default_nettype none

module bmsbi_back import bmsbi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_valid,
  input  wire value_tbl_t tbl,
  output bk_stat_t        bk_stat,
  input  wire logic       out_pop,
  output logic            out_empty,
  output logic [7:0]      out_tx_byte,
  output logic            out_frame_end
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } bk_state_t;

  bk_state_t   st_r, st_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  cur_byte;
  logic        is_last, push, q_full;

  assign cur_byte     = frame_byte(tbl, cnt_r, 16'd0 - sum_r);
  assign is_last      = (cnt_r == 6'(FrameLen - 1));
  assign push         = (st_r == ST_SEND) & ~q_full;
  assign bk_stat.take = job_valid & (st_r == ST_IDLE);
  assign bk_stat.busy = (st_r == ST_SEND);

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          st_nxt  = ST_SEND;
          cnt_nxt = 6'd0;
          sum_nxt = 16'd0;
        end
      end
      ST_SEND: begin
        if (push) begin
          cnt_nxt = cnt_r + 6'd1;
          // checksum covers bytes 2 through 36
          if (cnt_r >= 6'd2 && cnt_r <= 6'd36) sum_nxt = sum_r + {8'd0, cur_byte};
          if (is_last) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= 6'd0;
      sum_r <= 16'd0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  bmsbi_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push),
    .wr_byte   (cur_byte),
    .wr_end    (is_last),
    .q_full    (q_full),
    .pop       (out_pop),
    .empty     (out_empty),
    .tx_byte   (out_tx_byte),
    .frame_end (out_frame_end)
  );

endmodule

`default_nettype wire

// ----- hdl/bms_basic_info_responder_core.sv -----
// top level of the basic-info responder: delay register, front and back parts
// depends on bmsbi_pkg, bmsbi_front, bmsbi_back and assert_macros.svh
//
//   channel   ports                                           handshake
//   input     in_opcode in_rx_byte in_value_index in_value_data  in_push / in_full
//   result    out_tx_byte out_frame_end                        out_empty / out_pop
//   config    cfg_data (response delay, 10 bit)                cfg_valid / cfg_ready
//
// one input item per cycle while no frame is in flight
// a request that fires with a valid table holds in_full through the job slot and the serializer
// (one byte per cycle from the serializer while the result queue has room) and longer if out_pop stalls
// the two-entry result queue lets the serializer run up to two bytes ahead of the consumer
// synchronous active-low reset clears the value table and counters and sets the delay to 15 ms
`default_nettype none
`include "assert_macros.svh"

module bms_basic_info_responder_core import bmsbi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [4:0]  in_value_index,
  input  wire logic [31:0] in_value_data,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_tx_byte,
  output logic             out_frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data
);

  logic [9:0] delay_r, delay_nxt;
  logic       job_valid;
  value_tbl_t tbl;
  bk_stat_t   bk_stat;

  assign cfg_ready = 1'b1;
  assign delay_nxt = (cfg_valid & cfg_ready) ? cfg_data : delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
    end else begin
      delay_r <= delay_nxt;
    end
  end

  bmsbi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_rx_byte     (in_rx_byte),
    .in_value_index (in_value_index),
    .in_value_data  (in_value_data),
    .delay          (delay_r),
    .bk_stat        (bk_stat),
    .job_valid      (job_valid),
    .tbl            (tbl)
  );

  bmsbi_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .tbl           (tbl),
    .bk_stat       (bk_stat),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end)
  );

  `CHK_IMPL(a_full_while_busy, bk_stat.busy || job_valid, in_full, "item taken while a frame is in flight")
  `CHK_NEXT(a_job_taken, bk_stat.take, bk_stat.busy && !job_valid, "frame job not handed to serializer")
  `CHK_IMPL(a_end_is_stop, !out_empty && out_frame_end, out_tx_byte == BYTE_STOP, "frame end without stop byte")
  `CHK_IMPL(a_table_frozen, $past(bk_stat.busy) && bk_stat.busy, $stable(tbl), "value table changed mid-frame")

endmodule

`default_nettype wire

// ----- test/bms_basic_info_responder_core_tb.sv -----
`timescale 1ns / 100ps
// testbench for bms_basic_info_responder_core: feeds rx bytes, ms ticks, value writes, spare opcodes
// and delay settings, predicts every basic-info frame byte and checks the result queue against it
// depends on bmsbi_pkg and the responder rtl

module bms_basic_info_responder_core_tb;
  import bmsbi_pkg::*;

  localparam logic [1:0]  OP_SPARE       = 2'd3;
  localparam int          CYCLE_LIMIT    = 600000;
  localparam int          SETTLE_CYCLES  = 60;
  localparam logic [9:0]  DELAY_AT_RESET = 10'd15;
  localparam logic [9:0]  DELAY_LONGEST  = 10'd1000;
  localparam int          DELAY_LONG     = 40;
  localparam logic [9:0]  ELAPSED_TOP    = 10'd1023;
  localparam logic [7:0]  PENDING_TOP    = 8'd255;

  // read-basic-info command, first byte in the top bits
  localparam logic [55:0] REQ_CMD = 56'hDD_A5_03_00_FF_FD_77;

  localparam logic [7:0]  FR_START  = 8'hDD;
  localparam logic [7:0]  FR_READ   = 8'h03;
  localparam logic [7:0]  FR_STATUS = 8'h00;
  localparam logic [7:0]  FR_LEN    = 8'd33;
  localparam logic [7:0]  FR_STOP   = 8'h77;
  localparam logic [15:0] TEMP_BIAS = 16'd2731;
  localparam logic [15:0] YEAR_ZERO = 16'd2000;

  // value table entries
  localparam int V_VALID   = 0;
  localparam int V_VOLT    = 1;
  localparam int V_YEAR    = 6;
  localparam int V_MONTH   = 7;
  localparam int V_DAY     = 8;
  localparam int V_BALANCE = 9;
  localparam int V_PROT    = 10;
  localparam int V_SW      = 11;
  localparam int V_SOC     = 12;
  localparam int V_CHG     = 13;
  localparam int V_DSG     = 14;
  localparam int V_CELLS   = 15;
  localparam int V_NTC     = 16;
  localparam int V_TEMP0   = 17;

  // entries stored as 16 bit; the rest are 8 bit except the balance mask
  localparam logic [NumValues-1:0] HALF_WORD = 22'b11111_000000_1_000_111111_0;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } tx_rec_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_push        = 1'b0;
  logic [1:0]  in_opcode      = OP_RX;
  logic [7:0]  in_rx_byte     = 8'h00;
  logic [4:0]  in_value_index = 5'd0;
  logic [31:0] in_value_data  = 32'd0;
  logic        out_pop        = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic [9:0]  cfg_data       = 10'd0;
  logic        in_full;
  logic        out_empty;
  logic [7:0]  out_tx_byte;
  logic        out_frame_end;
  logic        cfg_ready;

  // responder state as the testbench sees it
  logic [31:0] bat_vals [NumValues];
  logic [2:0]  cmd_pos;
  logic [7:0]  req_pending;
  logic [9:0]  elapsed_ms;
  logic [9:0]  resp_delay;

  tx_rec_t tx_due_q [$];
  int      frames_due   = 0;
  int      items_sent   = 0;
  int      fail_cnt     = 0;
  int      cycle_cnt    = 0;
  int      gap_pct      = 0;
  int      pop_idle_pct = 0;
  int      pop_hold     = 0;

  bms_basic_info_responder_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_rx_byte     (in_rx_byte),
    .in_value_index (in_value_index),
    .in_value_data  (in_value_data),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_tx_byte    (out_tx_byte),
    .out_frame_end  (out_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] req_byte(input int pos);
    return REQ_CMD[8 * (CmdLen - 1 - pos) +: 8];
  endfunction

  function automatic logic [31:0] value_keep(input logic [4:0] idx);
    if (idx == V_BALANCE) return 32'hFFFF_FFFF;
    return HALF_WORD[idx] ? 32'h0000_FFFF : 32'h0000_00FF;
  endfunction

  task automatic queue_info_frame();
    logic [7:0]  fr [FrameLen];
    logic [15:0] words [9];
    logic [15:0] w;
    logic [15:0] csum;
    tx_rec_t     rec;
    int          k;
    for (k = 0; k < 5; k++) words[k] = bat_vals[V_VOLT + k][15:0];
    words[5] = ((bat_vals[V_YEAR][15:0] - YEAR_ZERO) << 9) | (bat_vals[V_MONTH][15:0] << 5) |
               bat_vals[V_DAY][15:0];
    words[6] = bat_vals[V_BALANCE][31:16];
    words[7] = bat_vals[V_BALANCE][15:0];
    words[8] = bat_vals[V_PROT][15:0];
    fr[0] = FR_START;
    fr[1] = FR_READ;
    fr[2] = FR_STATUS;
    fr[3] = FR_LEN;
    for (k = 0; k < 9; k++) begin
      fr[4 + 2 * k] = words[k][15:8];
      fr[5 + 2 * k] = words[k][7:0];
    end
    fr[22] = bat_vals[V_SW][7:0];
    fr[23] = bat_vals[V_SOC][7:0];
    fr[24] = {6'd0, bat_vals[V_DSG] != 32'd0, bat_vals[V_CHG] != 32'd0};
    fr[25] = bat_vals[V_CELLS][7:0];
    fr[26] = bat_vals[V_NTC][7:0];
    for (k = 0; k < 5; k++) begin
      w = bat_vals[V_TEMP0 + k][15:0] + TEMP_BIAS;
      fr[27 + 2 * k] = w[15:8];
      fr[28 + 2 * k] = w[7:0];
    end
    csum = 16'd0;
    for (k = 2; k < 37; k++) csum = csum + fr[k];
    csum = 16'd0 - csum;
    fr[37] = csum[15:8];
    fr[38] = csum[7:0];
    fr[39] = FR_STOP;
    for (k = 0; k < FrameLen; k++) begin
      rec.tx_byte   = fr[k];
      rec.frame_end = (k == FrameLen - 1);
      tx_due_q.push_back(rec);
    end
    frames_due++;
  endtask

  // advance the responder state by one accepted request
  task automatic track_item(input logic [1:0] op, input logic [7:0] rx, input logic [4:0] idx,
                            input logic [31:0] data);
    case (op)
      OP_RX: begin
        if (rx != req_byte(cmd_pos)) begin
          cmd_pos = 3'd0;
        end else if (cmd_pos == CmdLen - 1) begin
          cmd_pos = 3'd0;
          if (req_pending == 8'd0) elapsed_ms = 10'd0;
          if (req_pending != PENDING_TOP) req_pending++;
        end else begin
          cmd_pos++;
        end
      end
      OP_TICK: begin
        if (elapsed_ms != ELAPSED_TOP) elapsed_ms++;
      end
      OP_WRITE: begin
        if (idx < NumValues) bat_vals[idx] = data & value_keep(idx);
      end
      default: ;
    endcase
    // the answer check follows every request, whatever its opcode
    if (req_pending != 8'd0 && elapsed_ms >= resp_delay) begin
      req_pending--;
      elapsed_ms = 10'd0;
      if (bat_vals[V_VALID] != 32'd0) queue_info_frame();
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] rx, input logic [4:0] idx,
                           input logic [31:0] data);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_opcode      <= op;
    in_rx_byte     <= rx;
    in_value_index <= idx;
    in_value_data  <= data;
    do @(posedge clk); while (in_full !== 1'b0);
    track_item(op, rx, idx, data);
    items_sent++;
  endtask

  task automatic send_request();
    int k;
    for (k = 0; k < CmdLen; k++) send_item(OP_RX, req_byte(k), 5'($urandom), $urandom);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, 8'($urandom), 5'($urandom), $urandom);
  endtask

  task automatic write_value(input logic [4:0] idx, input logic [31:0] data);
    send_item(OP_WRITE, 8'($urandom), idx, data);
  endtask

  task automatic send_random_write();
    logic [4:0]  idx;
    logic [31:0] data;
    if ($urandom_range(0, 9) == 0) idx = 5'($urandom_range(NumValues, 31));
    else idx = 5'($urandom_range(0, NumValues - 1));
    case ($urandom_range(0, 5))
      0:       data = 32'd0;
      1:       data = 32'hFFFF_FFFF;
      2:       data = 32'h0000_8000;
      3:       data = 32'hFFFF_7FFF;
      default: data = $urandom;
    endcase
    // keep the table valid most of the time so frames keep coming
    if (idx == V_VALID && $urandom_range(0, 3) != 0) data[0] = 1'b1;
    write_value(idx, data);
  endtask

  // hold off input until every predicted byte is out, then let the block settle
  task automatic wait_idle();
    in_push <= 1'b0;
    while (tx_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_delay(input logic [9:0] d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    resp_delay = d;
  endtask

  // reset delay of 15 ms and an all-zero table
  task automatic test_reset_defaults();
    send_request();
    send_ticks(14);
    write_value(V_VALID, 32'h0000_005A);
    send_ticks(1);
  endtask

  // every entry written with all ones, out-of-range writes, immediate answer
  task automatic test_stored_widths();
    int k;
    wait_idle();
    set_delay(10'd0);
    for (k = 0; k < NumValues; k++) write_value(5'(k), 32'hFFFF_FFFF);
    write_value(5'(NumValues), $urandom);
    write_value(5'd31, $urandom);
    send_request();
  endtask

  // repeated start byte is not rechecked, spare opcode, invalid table
  task automatic test_command_framing();
    int k;
    send_item(OP_RX, req_byte(0), 5'($urandom), $urandom);
    for (k = 0; k < CmdLen; k++) send_item(OP_RX, req_byte(k), 5'($urandom), $urandom);
    send_item(OP_SPARE, 8'($urandom), 5'($urandom), $urandom);
    write_value(V_VALID, 32'h0000_0100);
    send_request();
    write_value(V_VALID, 32'h0000_0001);
    send_request();
  endtask

  // pending request released by a spare opcode after the delay is lowered
  task automatic test_delay_change_pending();
    wait_idle();
    set_delay(DELAY_LONGEST);
    send_request();
    send_ticks(3);
    wait_idle();
    set_delay(10'd3);
    send_item(OP_SPARE, 8'($urandom), 5'($urandom), $urandom);
  endtask

  // three requests queue up, then drain one per tick, one of them with an invalid table
  task automatic test_pending_drain();
    wait_idle();
    set_delay(DELAY_LONGEST);
    repeat (3) send_request();
    wait_idle();
    set_delay(10'd1);
    send_ticks(1);
    write_value(V_VALID, 32'd0);
    send_ticks(1);
    write_value(V_VALID, 32'h0000_00FF);
    send_ticks(2);
  endtask

  task automatic test_long_delay();
    wait_idle();
    set_delay(10'(DELAY_LONG));
    send_request();
    send_ticks(DELAY_LONG + 5);
  endtask

  task automatic test_random_mix(input int n, input logic [9:0] d, input int idle,
                                 input int min_frames);
    int stop_at;
    int start_frames;
    int pick;
    int len;
    int k;
    wait_idle();
    set_delay(d);
    gap_pct      = idle;
    pop_idle_pct = idle;
    stop_at      = items_sent + n;
    start_frames = frames_due;
    while ((items_sent < stop_at || frames_due - start_frames < min_frames) &&
           items_sent < stop_at + 3 * n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        for (k = 0; k < CmdLen; k++) begin
          if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 2))
              0:       send_ticks(1);
              1:       send_random_write();
              default: send_item(OP_SPARE, 8'($urandom), 5'($urandom), $urandom);
            endcase
          end
          send_item(OP_RX, req_byte(k), 5'($urandom), $urandom);
        end
      end else if (pick < 50) begin
        len = $urandom_range(0, CmdLen - 1);
        for (k = 0; k < len; k++) send_item(OP_RX, req_byte(k), 5'($urandom), $urandom);
        send_item(OP_RX, 8'($urandom), 5'($urandom), $urandom);
      end else if (pick < 75) begin
        send_ticks($urandom_range(1, d + 3));
      end else if (pick < 93) begin
        send_random_write();
      end else begin
        send_item($urandom_range(0, 1) ? OP_SPARE : OP_RX, 8'($urandom), 5'($urandom),
                  $urandom);
      end
    end
  endtask

  // result side stalls out_pop in random bursts while pop_idle_pct is nonzero
  always @(posedge clk) begin
    if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      out_pop  <= 1'b0;
    end else if (pop_idle_pct != 0 && $urandom_range(0, 99) < pop_idle_pct) begin
      pop_hold <= $urandom_range(0, 15);
      out_pop  <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_tx
    tx_rec_t want;
    if (rst_n === 1'b1 && out_pop === 1'b1 && out_empty === 1'b0) begin
      if (tx_due_q.size() == 0) begin
        $error("unexpected response byte: tx_byte %02h frame_end %0b",
               out_tx_byte, out_frame_end);
        fail_cnt++;
      end else begin
        want = tx_due_q.pop_front();
        if (out_tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %02h, actual %02h", want.tx_byte, out_tx_byte);
          fail_cnt++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, actual %0b", want.frame_end, out_frame_end);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int k;
    for (k = 0; k < NumValues; k++) bat_vals[k] = 32'd0;
    cmd_pos     = 3'd0;
    req_pending = 8'd0;
    elapsed_ms  = 10'd0;
    resp_delay  = DELAY_AT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_stored_widths();
    test_command_framing();
    test_delay_change_pending();
    test_pending_drain();
    test_long_delay();
    test_random_mix(50, 10'($urandom_range(1, 4)), 35, 3);
    test_random_mix(40, 10'($urandom_range(16, 24)), 15, 1);
    test_random_mix(40, 10'd0, 0, 3);
    wait_idle();
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bmsbi_pkg.sv
hdl/bmsbi_outq.sv
hdl/bmsbi_front.sv
hdl/bmsbi_back.sv
hdl/bms_basic_info_responder_core.sv
test/bms_basic_info_responder_core_tb.sv
